// ===== rtl/core/bcpe_pkg.sv =====
// Shared constants, types and the binomial table of the Bezier point evaluator.
`default_nettype none
package bcpe_pkg;

   localparam int MAX_POINTS    = 8;
   localparam int COORD_BITS    = 16;
   localparam int T_FRAC_BITS   = 16;

   localparam int DEG_W         = 3;
   localparam int IDX_W         = 3;
   localparam int PARAM_T_W     = 17;
   localparam int DEGREE_RESET  = 3;
   localparam int MAX_DEG       = MAX_POINTS - 1;

   localparam int T_W           = T_FRAC_BITS + 1;
   localparam int BINOM_W       = 6;
   localparam int CT_W          = BINOM_W + T_W;
   localparam int WP_W          = CT_W + T_W;
   localparam int W_W           = WP_W - T_FRAC_BITS;
   localparam int TERM_W        = W_W + 1 + COORD_BITS;
   localparam int ACC_W         = TERM_W + 4;

   localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC_BITS;
   localparam logic [T_W-1:0] T_HALF = T_W'(1) << (T_FRAC_BITS - 1);

   localparam logic [BINOM_W-1:0] BINOM_TABLE [0:7][0:7] = '{
      '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
      '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
      '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
   };

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_EVAL    = 2'd0,
      STATUS_WRITTEN = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWER,
      ST_WEIGHT,
      ST_MAC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                         write;
      logic                         push;
      logic                         rotate;
      logic signed [COORD_BITS-1:0] wr_x;
      logic signed [COORD_BITS-1:0] wr_y;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic        [CT_W-1:0]       ct;
   } cell_data_type;

endpackage
`default_nettype wire

// ===== rtl/core/bcpe_cell.sv =====
// One cell of the chain: a control point and one scaled power of t.
`default_nettype none
module bcpe_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bcpe_pkg::cell_ctrl_type ctrl,
   input  wire                          sel,
   input  wire                          is_last,
   input  wire  [bcpe_pkg::CT_W-1:0]    push_in,
   input  wire bcpe_pkg::cell_data_type rot_in,
   input  wire bcpe_pkg::cell_data_type wrap_in,
   output bcpe_pkg::cell_data_type      data_out
);
   import bcpe_pkg::*;

   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic        [CT_W-1:0]       ct_ff;
   cell_data_type                src;

   // the last cell in use closes the ring back to the head
   assign src = is_last ? wrap_in : rot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (ctrl.write && sel) begin
         x_ff <= ctrl.wr_x;
         y_ff <= ctrl.wr_y;
      end else if (ctrl.rotate) begin
         x_ff <= src.x;
         y_ff <= src.y;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         ct_ff <= push_in;
      end else if (ctrl.rotate) begin
         ct_ff <= src.ct;
      end
   end

   assign data_out = '{x: x_ff, y: y_ff, ct: ct_ff};

endmodule
`default_nettype wire

// ===== rtl/core/bezier_curve_point_eval_top.sv =====
// Top level of the Bezier point evaluator: sequencer, shared arithmetic and the cell chain.
// Usage:
//  req_ channel carries one command a beat: a control-point write or an evaluate at t.
//  rsp_ channel returns one beat per request: curve_x, curve_y and status.
//  csr_write_en / csr_write_data set the curve degree; write only while idle.
//  A write is answered in the cycle after acceptance. An evaluate first forms
//  the scaled powers of t in the chain, then takes two steps per control
//  point (weight, then multiply-accumulate while the ring turns by one),
//  then a final step to round and saturate.
//  The weight/accumulate loop on the shared multipliers sets the rate; one
//  item is in work at a time, so no new request is taken until it is done.
//  Reset clears all control points to zero and sets the degree to three.
//  The result waits in an output register while rsp_stall is high; a finished
//  evaluate holds in its final step until that register is free, and no new
//  request is taken while the output register is stalled.
`default_nettype none
module bezier_curve_point_eval_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_command,
   input  wire  [bcpe_pkg::IDX_W-1:0]            req_point_index,
   input  wire  signed [bcpe_pkg::COORD_BITS-1:0] req_point_x,
   input  wire  signed [bcpe_pkg::COORD_BITS-1:0] req_point_y,
   input  wire  [bcpe_pkg::PARAM_T_W-1:0]        req_param_t,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [bcpe_pkg::COORD_BITS-1:0] rsp_curve_x,
   output logic signed [bcpe_pkg::COORD_BITS-1:0] rsp_curve_y,
   output logic [1:0]                            rsp_status,
   input  wire                                   csr_write_en,
   input  wire  [bcpe_pkg::DEG_W-1:0]            csr_write_data
);
   import bcpe_pkg::*;

   state_type                    state_ff, state_in;
   logic [DEG_W-1:0]             degree_ff, n_eff, step_ff, step_in;
   logic [T_W-1:0]               t_ff, u_ff, tp_ff, up_ff, t_cl, tp_in, up_in;
   logic [W_W-1:0]               w_ff, w_in;
   logic signed [ACC_W-1:0]      acc_x_ff, acc_y_ff, acc_x_in, acc_y_in;
   logic [2*T_W-1:0]             tp_prod, up_prod;
   logic [CT_W-1:0]              ct_push;
   logic [WP_W-1:0]              w_prod;
   logic signed [TERM_W-1:0]     term_x, term_y;
   logic signed [ACC_W-1:0]      rnd_x, rnd_y;
   logic signed [COORD_BITS-1:0] sat_x, sat_y;

   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   status_type                   rsp_status_ff;

   logic req_fire, out_free, in_range, load_write, load_eval;

   cell_ctrl_type                ctrl;
   cell_data_type                cell_q [MAX_POINTS];

   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'($signed({1'b0, {(COORD_BITS-1){1'b1}}}));
   localparam logic signed [ACC_W-1:0] SAT_LO =
      ACC_W'($signed({1'b1, {(COORD_BITS-1){1'b0}}}));

   // ---------------- handshake ----------------
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) | ~out_free;
   assign req_fire  = req_valid & ~req_stall;

   assign n_eff    = (int'(degree_ff) > MAX_DEG) ? DEG_W'(MAX_DEG) : degree_ff;
   assign in_range = int'(req_point_index) <= int'(n_eff);

   assign t_cl = ({T_W'(0), req_param_t} > {PARAM_T_W'(0), T_ONE}) ?
                 T_ONE : T_W'(req_param_t);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_command == CMD_EVAL) state_in = ST_POWER;
         end
         ST_POWER: begin
            if (step_ff == n_eff) state_in = ST_WEIGHT;
         end
         ST_WEIGHT: state_in = ST_MAC;
         ST_MAC: begin
            state_in = (step_ff == n_eff) ? ST_FINISH : ST_WEIGHT;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl        = '0;
      ctrl.wr_x   = req_point_x;
      ctrl.wr_y   = req_point_y;
      load_write  = 1'b0;
      load_eval   = 1'b0;
      step_in     = '0;
      case (state_ff)
         ST_IDLE: begin
            load_write = req_fire && (req_command == CMD_WRITE);
            ctrl.write = load_write && in_range;
         end
         ST_POWER: begin
            ctrl.push = 1'b1;
            step_in   = (step_ff == n_eff) ? '0 : step_ff + 1'b1;
         end
         ST_WEIGHT: step_in = step_ff;
         ST_MAC: begin
            ctrl.rotate = 1'b1;
            step_in     = step_ff + 1'b1;
         end
         ST_FINISH: load_eval = out_free;
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         degree_ff <= DEG_W'(DEGREE_RESET);
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_write_en) degree_ff <= csr_write_data;
      end
   end

   // ---------------- shared arithmetic ----------------
   assign tp_prod = (2*T_W)'(tp_ff) * (2*T_W)'(t_ff);
   assign up_prod = (2*T_W)'(up_ff) * (2*T_W)'(u_ff);
   assign tp_in   = T_W'((tp_prod + (2*T_W)'(T_HALF)) >> T_FRAC_BITS);
   assign up_in   = T_W'((up_prod + (2*T_W)'(T_HALF)) >> T_FRAC_BITS);

   // C(n,k)*t^k enters the chain head; after the fill the head holds k = n
   assign ct_push = CT_W'(BINOM_TABLE[n_eff][step_ff]) * CT_W'(tp_ff);

   assign w_prod = WP_W'(cell_q[0].ct) * WP_W'(up_ff);
   assign w_in   = W_W'((w_prod + WP_W'(T_HALF)) >> T_FRAC_BITS);

   assign term_x   = $signed({1'b0, w_ff}) * $signed(cell_q[0].x);
   assign term_y   = $signed({1'b0, w_ff}) * $signed(cell_q[0].y);
   assign acc_x_in = acc_x_ff + ACC_W'(term_x);
   assign acc_y_in = acc_y_ff + ACC_W'(term_y);

   // floor((s + half) / one), then clamp
   assign rnd_x = (acc_x_ff + $signed(ACC_W'(T_HALF))) >>> T_FRAC_BITS;
   assign rnd_y = (acc_y_ff + $signed(ACC_W'(T_HALF))) >>> T_FRAC_BITS;
   assign sat_x = (rnd_x > SAT_HI) ? COORD_BITS'(SAT_HI) :
                  (rnd_x < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(rnd_x);
   assign sat_y = (rnd_y > SAT_HI) ? COORD_BITS'(SAT_HI) :
                  (rnd_y < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(rnd_y);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         t_ff     <= t_cl;
         u_ff     <= T_ONE - t_cl;
         tp_ff    <= T_ONE;
         up_ff    <= T_ONE;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else begin
         if (state_ff == ST_POWER) tp_ff <= tp_in;
         if (state_ff == ST_WEIGHT) begin
            w_ff  <= w_in;
            up_ff <= up_in;
         end
         if (state_ff == ST_MAC) begin
            acc_x_ff <= acc_x_in;
            acc_y_ff <= acc_y_in;
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_write || load_eval) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_write) begin
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_status_ff <= in_range ? STATUS_WRITTEN : STATUS_RANGE;
      end else if (load_eval) begin
         rsp_x_ff      <= sat_x;
         rsp_y_ff      <= sat_y;
         rsp_status_ff <= STATUS_EVAL;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_curve_x = rsp_x_ff;
   assign rsp_curve_y = rsp_y_ff;
   assign rsp_status  = rsp_status_ff;

   // ---------------- cell chain ----------------
   for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
      logic [CT_W-1:0] push_src;
      cell_data_type   rot_src;

      if (j == 0) begin : g_head
         assign push_src = ct_push;
      end else begin : g_body
         assign push_src = cell_q[j-1].ct;
      end

      // cells past the last one in use keep their points while the ring turns
      if (j == MAX_POINTS - 1) begin : g_tail
         assign rot_src = cell_q[j];
      end else begin : g_next
         assign rot_src = (j > int'(n_eff)) ? cell_q[j] : cell_q[j+1];
      end

      bcpe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .sel      (int'(req_point_index) == j),
         .is_last  (int'(n_eff) == j),
         .push_in  (push_src),
         .rot_in   (rot_src),
         .wrap_in  (cell_q[0]),
         .data_out (cell_q[j])
      );
   end

`ifndef SYNTHESIS
   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command == CMD_WRITE && in_range) |=>
      (rsp_valid && rsp_status == STATUS_WRITTEN))
      else $error("in-range write beat not answered as written");

   a_step_in_degree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WEIGHT) |-> (step_ff <= n_eff))
      else $error("weight step beyond degree");

   a_eval_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=>
      (rsp_valid && rsp_status == STATUS_EVAL && state_ff == ST_IDLE))
      else $error("evaluate result not delivered on finish");
`endif

endmodule
`default_nettype wire
